// ===== rtl/polynomial_multiplier_assert.svh =====
// Assertion macros used by the polynomial multiplier checker.
// Needs nothing else; include by bare file name.
`ifndef POLYNOMIAL_MULTIPLIER_ASSERT_SVH
`define POLYNOMIAL_MULTIPLIER_ASSERT_SVH

// same-cycle implication under asynchronous active-low reset
`define PM_ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("polynomial_multiplier assertion failed");

// next-cycle implication under asynchronous active-low reset
`define PM_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("polynomial_multiplier assertion failed");

`endif

// ===== rtl/polymul_pkg.sv =====
// Shared types, constants and width functions for the polynomial multiplier.
// No dependencies; imported by every module of the block.
package polymul_pkg;

	localparam int TERMS_DEF = 10;
	localparam int EXP_MAX_W = 6;    // exponent index for up to 64 terms
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;

	localparam logic [1:0] MODE_LOAD_A = 2'd0;
	localparam logic [1:0] MODE_LOAD_B = 2'd1;
	localparam logic [1:0] MODE_MUL    = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_MUL    = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [EXP_MAX_W-1:0]  exponent;
		logic signed [15:0]    coefficient;
	} cmd_t;

	function automatic int exp_bits(input int t);
		return $clog2(t);
	endfunction

	function automatic int oexp_bits(input int t);
		return $clog2(2 * t - 1);
	endfunction

	function automatic int coef_bits(input int t);
		return 31 + $clog2(t + 1);
	endfunction

	function automatic int in_bits(input int t);
		return ((18 + exp_bits(t) + 7) / 8) * 8;
	endfunction

	function automatic int out_bits(input int t);
		return ((oexp_bits(t) + coef_bits(t) + 7) / 8) * 8;
	endfunction

endpackage

// ===== rtl/polymul_front.sv =====
// Front end: accepts input words, classifies them and queues commands.
// Depends on polymul_pkg.
module polymul_front import polymul_pkg::*; #(
	parameter int TERMS = TERMS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [in_bits(TERMS)-1:0]  s_tdata,   // mode, exponent, coefficient
	output logic                       cmd_valid,
	input  logic                       cmd_ready,
	output cmd_t                       cmd
);

	localparam int EXP_W = exp_bits(TERMS);
	localparam logic [EXP_W:0] TERMS_V = (EXP_W + 1)'(TERMS);

	logic [1:0]          mode;
	logic [EXP_W-1:0]    exponent;
	logic signed [15:0]  coefficient;
	logic                keep;
	cmd_t                entry;
	cmd_t                fifo_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                push;
	logic                pop;

	assign mode        = s_tdata[1:0];
	assign exponent    = s_tdata[2 +: EXP_W];
	assign coefficient = s_tdata[2 + EXP_W +: 16];

	// drop unused modes and loads past the top exponent
	always_comb begin
		keep                    = 1'b0;
		entry.kind              = CMD_MUL;
		entry.exponent          = EXP_MAX_W'(exponent);
		entry.coefficient       = coefficient;
		case (mode)
			MODE_LOAD_A: begin
				entry.kind = CMD_LOAD_A;
				keep       = {1'b0, exponent} < TERMS_V;
			end
			MODE_LOAD_B: begin
				entry.kind = CMD_LOAD_B;
				keep       = {1'b0, exponent} < TERMS_V;
			end
			MODE_MUL: begin
				entry.kind = CMD_MUL;
				keep       = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign s_tready  = count_q != (QPTR_W + 1)'(QDEPTH);
	assign push      = s_tvalid && s_tready && keep;
	assign cmd_valid = count_q != '0;
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/polymul_back.sv =====
// Back end: coefficient stores, multiplier row, product accumulator and term emitter.
// Depends on polymul_pkg; fed by polymul_front.
module polymul_back import polymul_pkg::*; #(
	parameter int TERMS = TERMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  cmd_t                        cmd,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [out_bits(TERMS)-1:0]  m_tdata,   // term_exponent, term_coefficient
	output logic                        m_tlast
);

	localparam int EXP_W  = exp_bits(TERMS);
	localparam int OEXP_W = oexp_bits(TERMS);
	localparam int COEF_W = coef_bits(TERMS);
	localparam int OUT_BW = out_bits(TERMS);
	localparam int SUMS   = 2 * TERMS - 1;
	localparam logic [EXP_W-1:0]  I_TOP = EXP_W'(TERMS - 1);
	localparam logic [OEXP_W-1:0] E_TOP = OEXP_W'(SUMS - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} back_state_t;

	back_state_t               state_q;
	logic signed [15:0]        a_mem [TERMS];
	logic [TERMS-1:0]          a_vld_q;
	logic signed [15:0]        b_q [TERMS];
	logic [EXP_W-1:0]          i_q;
	logic [EXP_W-1:0]          idx;
	logic                      take;
	logic                      ld_a;
	logic                      ld_b;
	logic                      run_s1;
	logic                      first_s1;
	logic                      last_s1;
	logic                      a_ok_s1;
	logic signed [15:0]        a_rd_s1;
	logic signed [15:0]        a_eff;
	logic signed [31:0]        prod_s2 [TERMS];
	logic                      run_s2;
	logic                      first_s2;
	logic                      last_s2;
	logic                      done_s3;
	logic signed [COEF_W-1:0]  acc_q [SUMS];
	logic signed [COEF_W-1:0]  acc_d [SUMS];
	logic [SUMS-1:0]           mask_q;
	logic [OEXP_W-1:0]         cnt_q;
	logic                      any_q;
	logic                      out_free;
	logic                      emit_step;
	logic                      emit_term;
	logic                      emit_zero;
	logic                      out_valid_q;
	logic [OEXP_W-1:0]         out_exp_q;
	logic [COEF_W-1:0]         out_coef_q;
	logic                      out_last_q;

	assign cmd_ready = state_q == ST_IDLE;
	assign take      = cmd_ready && cmd_valid;
	assign idx       = cmd.exponent[EXP_W-1:0];
	assign ld_a      = take && cmd.kind == CMD_LOAD_A;
	assign ld_b      = take && cmd.kind == CMD_LOAD_B;

	assign out_free  = !out_valid_q || m_tready;
	assign emit_step = state_q == ST_EMIT && out_free && mask_q != '0;
	assign emit_term = emit_step && mask_q[SUMS-1];
	assign emit_zero = state_q == ST_EMIT && out_free && mask_q == '0 && !any_q;

	// coefficient store A: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ld_a) begin
			a_mem[idx] <= cmd.coefficient;
		end
		a_rd_s1 <= a_mem[i_q];
	end

	assign a_eff = a_ok_s1 ? a_rd_s1 : 16'sd0;

	// multiplier row: one A coefficient against every B lane
	always_ff @(posedge clk) begin
		for (int j = 0; j < TERMS; j++) begin
			prod_s2[j] <= 32'(a_eff) * 32'(b_q[j]);
		end
	end

	// Horner step: shift the partial product up one exponent, add the new row; while emitting, shift the sums up one place
	always_comb begin
		for (int k = 0; k < SUMS; k++) begin
			acc_d[k] = acc_q[k];
			if (run_s2) begin
				acc_d[k] = ((k == 0 || first_s2) ? '0 : acc_q[(k == 0) ? 0 : k - 1])
					+ ((k < TERMS) ? COEF_W'(prod_s2[(k < TERMS) ? k : 0]) : '0);
			end else if (emit_step) begin
				acc_d[k] = (k == 0) ? '0 : acc_q[(k == 0) ? 0 : k - 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < SUMS; k++) begin
			acc_q[k] <= acc_d[k];
		end
	end

	always_ff @(posedge clk) begin
		if (emit_zero) begin
			out_exp_q  <= '0;
			out_coef_q <= '0;
			out_last_q <= 1'b1;
		end else if (emit_term) begin
			out_exp_q  <= E_TOP - cnt_q;
			out_coef_q <= acc_q[SUMS-1];
			out_last_q <= mask_q[SUMS-2:0] == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			a_vld_q     <= '0;
			for (int j = 0; j < TERMS; j++) begin
				b_q[j] <= '0;
			end
			i_q         <= '0;
			run_s1      <= 1'b0;
			first_s1    <= 1'b0;
			last_s1     <= 1'b0;
			a_ok_s1     <= 1'b0;
			run_s2      <= 1'b0;
			first_s2    <= 1'b0;
			last_s2     <= 1'b0;
			done_s3     <= 1'b0;
			mask_q      <= '0;
			cnt_q       <= '0;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			run_s1   <= state_q == ST_RUN;
			first_s1 <= i_q == I_TOP;
			last_s1  <= i_q == '0;
			a_ok_s1  <= a_vld_q[i_q];
			run_s2   <= run_s1;
			first_s2 <= first_s1;
			last_s2  <= run_s1 && last_s1;
			done_s3  <= run_s2 && last_s2;

			if (ld_a) begin
				a_vld_q[idx] <= 1'b1;
			end
			if (ld_b) begin
				b_q[idx] <= cmd.coefficient;
			end
			// both stores clear once the last row has left the multipliers
			if (run_s2 && last_s2) begin
				a_vld_q <= '0;
				for (int j = 0; j < TERMS; j++) begin
					b_q[j] <= '0;
				end
			end

			if (emit_zero || emit_term) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (take && cmd.kind == CMD_MUL) begin
						i_q     <= I_TOP;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					i_q <= i_q - 1'b1;
					if (i_q == '0) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (done_s3) begin
						for (int k = 0; k < SUMS; k++) begin
							mask_q[k] <= acc_q[k] != '0;
						end
						cnt_q   <= '0;
						any_q   <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (mask_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							mask_q <= {mask_q[SUMS-2:0], 1'b0};
							cnt_q  <= cnt_q + 1'b1;
							if (mask_q[SUMS-1]) begin
								any_q <= 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_BW'({out_coef_q, out_exp_q});

endmodule

// ===== rtl/polynomial_multiplier.sv =====
// Polynomial multiplier top level: front end with command queue, back end with
// multiplier row and term emitter. Depends on polymul_pkg, polymul_front, polymul_back.
//
// Usage:
//   Slave stream s_* carries one word per command: mode (load A, load B or
//   multiply), exponent and signed 16-bit coefficient. Loads with an exponent of
//   TERMS or more and the unused mode are accepted and dropped.
//   Master stream m_* carries product terms, highest exponent first, only the
//   nonzero ones; tlast marks the final term. An all-zero product gives a single
//   zero term with tlast set. After a multiply both coefficient stores read zero.
// Timing:
//   A multiply runs the multiplier row over all A coefficients (one A coefficient
//   against all B coefficients per cycle), then drains the pipeline and sets up the
//   mask, then scans the sums, one exponent per cycle while the output is free.
//   Words queue four deep.
// Reset and stall:
//   arst_n clears the queue, both coefficient stores and the output valid flag.
//   While m_tready is low a valid output word holds and the scan pauses; the queue
//   keeps accepting until it is full.
module polynomial_multiplier import polymul_pkg::*; #(
	parameter int TERMS = TERMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [in_bits(TERMS)-1:0]   s_tdata,   // mode, exponent, coefficient
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [out_bits(TERMS)-1:0]  m_tdata,   // term_exponent, term_coefficient
	output logic                        m_tlast    // last_term
);

	logic  cmd_valid;
	logic  cmd_ready;
	cmd_t  cmd;

	polymul_front #(
		.TERMS (TERMS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	polymul_back #(
		.TERMS (TERMS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== rtl/polymul_checker.sv =====
// Port-level checks for the polynomial multiplier, bound to the top level.
// Depends on polymul_pkg and polynomial_multiplier_assert.svh.
`include "polynomial_multiplier_assert.svh"

module polymul_checker import polymul_pkg::*; #(
	parameter int TERMS = TERMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [out_bits(TERMS)-1:0]  m_tdata,   // term_exponent, term_coefficient
	input  logic                        m_tlast
);

	localparam int OEXP_W = oexp_bits(TERMS);
	localparam int COEF_W = coef_bits(TERMS);

	logic [OEXP_W-1:0] exp_w;
	logic [COEF_W-1:0] coef_w;
	logic [OEXP_W-1:0] prev_exp_q;
	logic              in_run_q;

	assign exp_w  = m_tdata[OEXP_W-1:0];
	assign coef_w = m_tdata[OEXP_W +: COEF_W];

	// remember the exponent of the previous word of an unfinished product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q   <= 1'b0;
			prev_exp_q <= '0;
		end else if (m_tvalid && m_tready) begin
			in_run_q   <= !m_tlast;
			prev_exp_q <= exp_w;
		end
	end

	`PM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	`PM_ASSERT_IMPLY(a_descending, clk, arst_n, m_tvalid && in_run_q, exp_w < prev_exp_q)
	`PM_ASSERT_IMPLY(a_zero_term, clk, arst_n, m_tvalid && coef_w == '0,
		m_tlast && exp_w == '0 && !in_run_q)

endmodule

bind polynomial_multiplier polymul_checker #(
	.TERMS (TERMS)
) u_polymul_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
